>>> hw/rtl/pidb_pkg.sv
// shared constants, types and helpers of the particle drag and buoyancy core
package pidb_pkg;

	// fixed point format
	localparam int FRAC_BITS = 16;
	localparam logic [FRAC_BITS-1:0] FRAC_MASK = '1;

	// field widths
	localparam int VW   = 32;
	localparam int CW   = 31;
	localparam int AXES = 3;
	localparam int IN_W  = 7 * VW;
	localparam int OUT_W = AXES * VW;
	localparam int CFG_IDX_W = 3;

	// drag division: quotient magnitude never exceeds 2^31
	localparam int QB    = VW;
	localparam int DEN_W = 32;
	localparam int NUM_W = DEN_W + QB;

	// change length and clamp
	localparam int DW       = VW + 1;
	localparam int SUM_W    = 64;
	localparam int ROOT_W   = SUM_W / 2;
	localparam int ROOT_RW  = ROOT_W + 2;
	localparam int LEN_W    = ROOT_W + 1;
	localparam int PROD_W   = DW + FRAC_BITS + 1;

	// buoyancy and saturation
	localparam int BUOY_W = 2 * VW + 1;
	localparam int SAT_W  = BUOY_W + 1;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DRAG_COEF = 3'd0,
		REG_TIME_STEP = 3'd1,
		REG_MAX_DRAG  = 3'd2,
		REG_AMBIENT   = 3'd3,
		REG_BUOY_GAIN = 3'd4,
		REG_MAX_ACCEL = 3'd5
	} cfg_reg_t;

	// per-particle payload that rides along the long pipeline
	typedef struct packed {
		logic                          surf;
		logic [AXES-1:0][VW-1:0]       vel;
		logic [AXES-1:0][DW-1:0]       dv;
		logic                          shr;
		logic                          clamp;
		logic [BUOY_W-1:0]             buoy;
	} side_t;

	// saturate a wide signed value to the velocity range
	function automatic logic [VW-1:0] sat_v(input logic signed [SAT_W-1:0] x);
		logic [VW-1:0] r;
		if ((&x[SAT_W-1:VW-1]) || !(|x[SAT_W-1:VW-1])) begin
			r = x[VW-1:0];
		end else if (x[SAT_W-1]) begin
			r = {1'b1, {(VW-1){1'b0}}};
		end else begin
			r = {1'b0, {(VW-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/particle_implicit_drag_buoyancy_core.sv
// particle implicit drag and clamped buoyancy core, top level
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata: vel xyz, gas vel xyz, gas temp; tuser: near_surface
//  m_*       out  m_tvalid/m_tready  tdata: new vel xyz; tuser: was_coupled
//  cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
//  one particle per cycle while the output is taken; most of the pipeline depth
//  comes from the bit-per-stage drag divider and the square root stages
//  the whole pipeline advances together; it holds while the output waits
//  reset clears the stage valid bits and loads the register defaults
//  the drag factor k_q is registered from the configuration registers, and the divisor den_q from k_q
module particle_implicit_drag_buoyancy_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// vel_x, vel_y, vel_z, gas_vel_x, gas_vel_y, gas_vel_z, gas_temp
	input  logic [pidb_pkg::IN_W-1:0]           s_tdata,
	// near_surface
	input  logic [0:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// new_vel_x, new_vel_y, new_vel_z
	output logic [pidb_pkg::OUT_W-1:0]          m_tdata,
	// was_coupled
	output logic [0:0]                          m_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pidb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pidb_pkg::VW-1:0]             cfg_data
);
	import pidb_pkg::*;

	// configuration registers
	logic [CW-1:0]        drag_q, step_q, maxd_q, maxa_q;
	logic signed [VW-1:0] amb_q, gain_q;
	logic [CW-1:0]        k_q;
	logic [DEN_W-1:0]     den_q;
	logic [2*CW-1:0]      kprod;
	logic [2*CW-1:0]      ksh;

	logic en;

	// pipeline stages
	logic                          vld_s1, vld_s2, vld_s3;
	side_t                         side_s1, side_s2, side_s3;
	logic [AXES-1:0][VW-1:0]       gas_s1;
	logic signed [VW-1:0]          temp_s1;
	logic [AXES-1:0][2*VW-1:0]     kg_s2;
	logic [VW-1:0]                 dtemp_s2;
	logic [AXES-1:0][NUM_W-1:0]    mag_s3;
	logic [AXES-1:0]               neg_s3;

	logic                          vld_dv;
	side_t                         side_dv;
	logic [AXES-1:0][VW-1:0]       quo_dv;

	logic                          vld_s4, vld_s5, vld_s6;
	side_t                         side_s4, side_s5, side_s6;
	logic [AXES-1:0][VW-1:0]       mag_s4;
	logic [AXES-1:0][2*CW-1:0]     sq_s5;
	logic [SUM_W-1:0]              sum_s6;

	logic                          vld_sq;
	side_t                         side_sq;
	logic [ROOT_W-1:0]             root_sq;

	logic                          vld_s7;
	side_t                         side_s7;
	logic [LEN_W-1:0]              len_s7;

	logic                          vld_sd;
	side_t                         side_sd;
	logic [FRAC_BITS-1:0]          ratio_sd;

	logic                          vld_s8, vld_s9, vld_s10;
	side_t                         side_s8, side_s9;
	logic [AXES-1:0][PROD_W-1:0]   prod_s8;
	logic [AXES-1:0][VW-1:0]       nv_s9;
	logic [OUT_W-1:0]              data_s10;
	logic                          coupled_s10;

	// combinational helpers
	side_t                         side_in, side_nx3, side_nx4, side_nx5, side_nx6, side_nx7;
	logic signed [DW-1:0]          dv_c   [AXES];
	logic [DW-1:0]                 dmag_c [AXES];
	logic signed [VW:0]            dtemp_c;
	logic signed [NUM_W-1:0]       num_c  [AXES];
	logic signed [BUOY_W-1:0]      badj_c, bsh_c, bmax_c;
	logic signed [VW-1:0]          acl_c;
	logic signed [2*VW-1:0]        aprod_c;
	logic signed [BUOY_W-1:0]      boost_c;
	logic [CW-1:0]                 m_c    [AXES];
	logic signed [PROD_W-1:0]      padj_c [AXES];
	logic signed [PROD_W-1:0]      psh_c  [AXES];
	logic signed [SAT_W-1:0]       nsum_c [AXES];
	logic signed [SAT_W-1:0]       ysum_c;
	logic [VW-1:0]                 ny_c;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drag_q <= CW'(65536);
			step_q <= CW'(1092);
			maxd_q <= CW'(65536);
			amb_q  <= '0;
			gain_q <= VW'(65536);
			maxa_q <= CW'(131072);
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_DRAG_COEF: drag_q <= cfg_data[CW-1:0];
				REG_TIME_STEP: step_q <= cfg_data[CW-1:0];
				REG_MAX_DRAG:  maxd_q <= cfg_data[CW-1:0];
				REG_AMBIENT:   amb_q  <= cfg_data;
				REG_BUOY_GAIN: gain_q <= cfg_data;
				REG_MAX_ACCEL: maxa_q <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// drag factor k = C*dt / 2^F saturated, and the divisor 2^F + k
	assign kprod = drag_q * step_q;
	assign ksh   = kprod >> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= '0;
			den_q <= '0;
		end else begin
			k_q   <= (|ksh[2*CW-1:CW]) ? {CW{1'b1}} : ksh[CW-1:0];
			den_q <= DEN_W'({1'b1, {FRAC_BITS{1'b0}}}) + DEN_W'(k_q);
		end
	end

	// whole pipeline moves unless the output holds a result not yet taken
	assign en       = !vld_s10 || m_tready;
	assign s_tready = en;

	// input unpack
	always_comb begin
		side_in = '0;
		side_in.surf = s_tuser[0];
		for (int a = 0; a < AXES; a++) begin
			side_in.vel[a] = s_tdata[a*VW +: VW];
		end
	end

	// valid bits of the top-level stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s1  <= s_tvalid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_dv;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_sq;
			vld_s8  <= vld_sd;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	// temperature excess, drag numerators and the raw buoyancy product
	always_comb begin
		dtemp_c = $signed({temp_s1[VW-1], temp_s1}) - $signed({amb_q[VW-1], amb_q});
		for (int a = 0; a < AXES; a++) begin
			num_c[a] = ($signed(NUM_W'($signed(side_s2.vel[a]))) <<< FRAC_BITS)
				+ $signed(kg_s2[a]);
		end
		side_nx3      = side_s2;
		side_nx3.buoy = $signed(gain_q) * $signed({1'b0, dtemp_s2});
	end

	// stages 1 to 3: capture, products, numerator magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			for (int a = 0; a < AXES; a++) begin
				gas_s1[a] <= s_tdata[(AXES+a)*VW +: VW];
			end
			temp_s1 <= s_tdata[2*AXES*VW +: VW];

			side_s2  <= side_s1;
			dtemp_s2 <= dtemp_c[VW] ? '0 : dtemp_c[VW-1:0];
			for (int a = 0; a < AXES; a++) begin
				kg_s2[a] <= $signed({1'b0, k_q}) * $signed(gas_s1[a]);
			end

			side_s3 <= side_nx3;
			for (int a = 0; a < AXES; a++) begin
				neg_s3[a] <= num_c[a][NUM_W-1];
				mag_s3[a] <= num_c[a][NUM_W-1] ? NUM_W'(-num_c[a]) : NUM_W'(num_c[a]);
			end
		end
	end

	pidb_drag_div u_drag_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.in_side   (side_s3),
		.in_mag    (mag_s3),
		.in_neg    (neg_s3),
		.den       (den_q),
		.out_valid (vld_dv),
		.out_side  (side_dv),
		.out_quo   (quo_dv)
	);

	// velocity change, clamped acceleration
	always_comb begin
		side_nx4 = side_dv;
		side_nx4.shr = 1'b0;
		for (int a = 0; a < AXES; a++) begin
			dv_c[a]   = $signed({quo_dv[a][VW-1], quo_dv[a]})
				- $signed({side_dv.vel[a][VW-1], side_dv.vel[a]});
			dmag_c[a] = dv_c[a][DW-1] ? DW'(-dv_c[a]) : DW'(dv_c[a]);
			side_nx4.dv[a] = dv_c[a];
			if (dmag_c[a][VW-1]) begin
				side_nx4.shr = 1'b1;
			end
		end
		badj_c = $signed(side_dv.buoy)
			+ (side_dv.buoy[BUOY_W-1] ? BUOY_W'(FRAC_MASK) : BUOY_W'(0));
		bsh_c  = badj_c >>> FRAC_BITS;
		bmax_c = $signed(BUOY_W'(maxa_q));
		if (bsh_c > bmax_c) begin
			acl_c = VW'(bmax_c);
		end else if (bsh_c < -bmax_c) begin
			acl_c = VW'(-bmax_c);
		end else begin
			acl_c = bsh_c[VW-1:0];
		end
		side_nx4.buoy = BUOY_W'(acl_c);
	end

	// squared components and the time step product
	always_comb begin
		side_nx5 = side_s4;
		for (int a = 0; a < AXES; a++) begin
			m_c[a] = CW'(mag_s4[a] >> side_s4.shr);
		end
		aprod_c = $signed(side_s4.buoy[VW-1:0]) * $signed({1'b0, step_q});
		side_nx5.buoy = BUOY_W'(aprod_c);
	end

	// sum of squares and the velocity boost
	always_comb begin
		side_nx6 = side_s5;
		boost_c  = $signed(side_s5.buoy)
			+ (side_s5.buoy[BUOY_W-1] ? BUOY_W'(FRAC_MASK) : BUOY_W'(0));
		side_nx6.buoy = boost_c >>> FRAC_BITS;
	end

	// stages 4 to 6
	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_nx4;
			for (int a = 0; a < AXES; a++) begin
				mag_s4[a] <= dmag_c[a][VW-1:0];
			end
			side_s5 <= side_nx5;
			for (int a = 0; a < AXES; a++) begin
				sq_s5[a] <= m_c[a] * m_c[a];
			end
			side_s6 <= side_nx6;
			sum_s6  <= SUM_W'(sq_s5[0]) + SUM_W'(sq_s5[1]) + SUM_W'(sq_s5[2]);
		end
	end

	pidb_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s6),
		.in_side   (side_s6),
		.in_sum    (sum_s6),
		.out_valid (vld_sq),
		.out_side  (side_sq),
		.out_root  (root_sq)
	);

	// change length and clamp decision
	always_comb begin
		side_nx7 = side_sq;
		side_nx7.clamp = (side_sq.shr ? {root_sq, 1'b0} : {1'b0, root_sq})
			> {{(LEN_W-CW){1'b0}}, maxd_q};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s7 <= side_nx7;
			len_s7  <= side_sq.shr ? {root_sq, 1'b0} : {1'b0, root_sq};
		end
	end

	pidb_scale_div u_scale_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (vld_s7),
		.in_side    (side_s7),
		.in_len     (len_s7),
		.max_change (maxd_q),
		.out_valid  (vld_sd),
		.out_side   (side_sd),
		.out_ratio  (ratio_sd)
	);

	// scaled change, new velocity, buoyancy on y
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			padj_c[a] = $signed(prod_s8[a])
				+ (prod_s8[a][PROD_W-1] ? PROD_W'(FRAC_MASK) : PROD_W'(0));
			psh_c[a]  = padj_c[a] >>> FRAC_BITS;
			if (side_s8.clamp) begin
				nsum_c[a] = $signed(SAT_W'($signed(side_s8.vel[a])))
					+ $signed(SAT_W'(psh_c[a]));
			end else begin
				nsum_c[a] = $signed(SAT_W'($signed(side_s8.vel[a])))
					+ $signed(SAT_W'($signed(side_s8.dv[a])));
			end
		end
		ysum_c = $signed(SAT_W'($signed(nv_s9[1]))) + $signed(SAT_W'($signed(side_s9.buoy)));
		ny_c   = sat_v(ysum_c);
	end

	// stages 8 to 10, the last one is the output register
	always_ff @(posedge clk) begin
		if (en) begin
			side_s8 <= side_sd;
			for (int a = 0; a < AXES; a++) begin
				prod_s8[a] <= $signed(side_sd.dv[a]) * $signed({1'b0, ratio_sd});
			end
			side_s9 <= side_s8;
			for (int a = 0; a < AXES; a++) begin
				nv_s9[a] <= sat_v(nsum_c[a]);
			end
			coupled_s10 <= side_s9.surf;
			if (side_s9.surf) begin
				data_s10 <= {nv_s9[2], ny_c, nv_s9[0]};
			end else begin
				data_s10 <= {side_s9.vel[2], side_s9.vel[1], side_s9.vel[0]};
			end
		end
	end

	assign m_tvalid   = vld_s10;
	assign m_tdata    = data_s10;
	assign m_tuser[0] = coupled_s10;

endmodule

>>> hw/rtl/pidb_drag_div.sv
// pipelined restoring divider for the implicit drag, one quotient bit per stage, three lanes
module pidb_drag_div (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              en,
	input  logic                                              in_valid,
	input  pidb_pkg::side_t                                   in_side,
	input  logic [pidb_pkg::AXES-1:0][pidb_pkg::NUM_W-1:0]    in_mag,
	input  logic [pidb_pkg::AXES-1:0]                         in_neg,
	input  logic [pidb_pkg::DEN_W-1:0]                        den,
	output logic                                              out_valid,
	output pidb_pkg::side_t                                   out_side,
	output logic [pidb_pkg::AXES-1:0][pidb_pkg::VW-1:0]       out_quo
);
	import pidb_pkg::*;

	logic [QB-1:0]                       vld_s;
	side_t                               side_s [QB];
	logic [DEN_W-1:0]                    rem_s  [QB][AXES];
	logic [QB-1:0]                       low_s  [QB][AXES];
	logic [AXES-1:0]                     neg_s  [QB];
	logic [DEN_W-1:0]                    rem_p  [QB][AXES];
	logic [QB-1:0]                       low_p  [QB][AXES];
	logic [DEN_W:0]                      trial  [QB][AXES];
	logic                                ge     [QB][AXES];
	logic [DEN_W-1:0]                    rem_nx [QB][AXES];
	logic [QB-1:0]                       low_nx [QB][AXES];
	logic                                vld_o_q;
	side_t                               side_o_s;
	logic [AXES-1:0][VW-1:0]             quo_o_s;

	// one shift and subtract step per stage
	always_comb begin
		for (int j = 0; j < QB; j++) begin
			for (int a = 0; a < AXES; a++) begin
				if (j == 0) begin
					rem_p[j][a] = in_mag[a][NUM_W-1:QB];
					low_p[j][a] = in_mag[a][QB-1:0];
				end else begin
					rem_p[j][a] = rem_s[j-1][a];
					low_p[j][a] = low_s[j-1][a];
				end
				trial[j][a]  = {rem_p[j][a], low_p[j][a][QB-1]};
				ge[j][a]     = trial[j][a] >= {1'b0, den};
				rem_nx[j][a] = ge[j][a] ? DEN_W'(trial[j][a] - {1'b0, den})
					: trial[j][a][DEN_W-1:0];
				low_nx[j][a] = {low_p[j][a][QB-2:0], ge[j][a]};
			end
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s   <= '0;
			vld_o_q <= 1'b0;
		end else if (en) begin
			vld_s   <= {vld_s[QB-2:0], in_valid};
			vld_o_q <= vld_s[QB-1];
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < QB; j++) begin
				side_s[j] <= (j == 0) ? in_side : side_s[j-1];
				neg_s[j]  <= (j == 0) ? in_neg : neg_s[j-1];
				for (int a = 0; a < AXES; a++) begin
					rem_s[j][a] <= rem_nx[j][a];
					low_s[j][a] <= low_nx[j][a];
				end
			end
			side_o_s <= side_s[QB-1];
			for (int a = 0; a < AXES; a++) begin
				quo_o_s[a] <= neg_s[QB-1][a] ? VW'(-low_s[QB-1][a]) : low_s[QB-1][a];
			end
		end
	end

	assign out_valid = vld_o_q;
	assign out_side  = side_o_s;
	assign out_quo   = quo_o_s;

	// partial remainder always stays below the divisor
	for (genvar gj = 0; gj < QB; gj++) begin : g_chk
		for (genvar ga = 0; ga < AXES; ga++) begin : g_lane
			assert property (@(posedge clk) disable iff (!arst_n)
				vld_s[gj] |-> (rem_s[gj][ga] < den))
				else $error("drag divider remainder not below divisor");
		end
	end

endmodule

>>> hw/rtl/pidb_isqrt.sv
// pipelined digit-by-digit integer square root of the squared change length
module pidb_isqrt (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  pidb_pkg::side_t                  in_side,
	input  logic [pidb_pkg::SUM_W-1:0]       in_sum,
	output logic                             out_valid,
	output pidb_pkg::side_t                  out_side,
	output logic [pidb_pkg::ROOT_W-1:0]      out_root
);
	import pidb_pkg::*;

	logic [ROOT_W-1:0]   vld_s;
	side_t               side_s [ROOT_W];
	logic [ROOT_RW-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0]   root_s [ROOT_W];
	logic [SUM_W-1:0]    low_s  [ROOT_W];
	logic [ROOT_RW-1:0]  rem_p  [ROOT_W];
	logic [ROOT_W-1:0]   root_p [ROOT_W];
	logic [SUM_W-1:0]    low_p  [ROOT_W];
	logic [ROOT_RW+1:0]  cur    [ROOT_W];
	logic [ROOT_RW+1:0]  trial  [ROOT_W];
	logic                ge     [ROOT_W];

	// one result bit per stage, two radicand bits brought down
	always_comb begin
		for (int j = 0; j < ROOT_W; j++) begin
			if (j == 0) begin
				rem_p[j]  = '0;
				root_p[j] = '0;
				low_p[j]  = in_sum;
			end else begin
				rem_p[j]  = rem_s[j-1];
				root_p[j] = root_s[j-1];
				low_p[j]  = low_s[j-1];
			end
			cur[j]   = {rem_p[j], low_p[j][SUM_W-1:SUM_W-2]};
			trial[j] = {2'b00, root_p[j], 2'b01};
			ge[j]    = cur[j] >= trial[j];
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[ROOT_W-2:0], in_valid};
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < ROOT_W; j++) begin
				side_s[j] <= (j == 0) ? in_side : side_s[j-1];
				rem_s[j]  <= ge[j] ? ROOT_RW'(cur[j] - trial[j]) : cur[j][ROOT_RW-1:0];
				root_s[j] <= {root_p[j][ROOT_W-2:0], ge[j]};
				low_s[j]  <= {low_p[j][SUM_W-3:0], 2'b00};
			end
		end
	end

	assign out_valid = vld_s[ROOT_W-1];
	assign out_side  = side_s[ROOT_W-1];
	assign out_root  = root_s[ROOT_W-1];

	// remainder never exceeds twice the partial root
	for (genvar gj = 0; gj < ROOT_W; gj++) begin : g_chk
		assert property (@(posedge clk) disable iff (!arst_n)
			vld_s[gj] |-> (rem_s[gj] <= {1'b0, root_s[gj], 1'b0}))
			else $error("square root remainder out of bound");
	end

endmodule

>>> hw/rtl/pidb_scale_div.sv
// pipelined divider for the clamp ratio max_drag_change * 2^F / length
module pidb_scale_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  pidb_pkg::side_t                   in_side,
	input  logic [pidb_pkg::LEN_W-1:0]        in_len,
	input  logic [pidb_pkg::CW-1:0]           max_change,
	output logic                              out_valid,
	output pidb_pkg::side_t                   out_side,
	output logic [pidb_pkg::FRAC_BITS-1:0]    out_ratio
);
	import pidb_pkg::*;

	logic [FRAC_BITS-1:0]  vld_s;
	side_t                 side_s [FRAC_BITS];
	logic [LEN_W-1:0]      len_s  [FRAC_BITS];
	logic [LEN_W-1:0]      rem_s  [FRAC_BITS];
	logic [FRAC_BITS-1:0]  quo_s  [FRAC_BITS];
	logic [LEN_W-1:0]      len_p  [FRAC_BITS];
	logic [LEN_W-1:0]      rem_p  [FRAC_BITS];
	logic [FRAC_BITS-1:0]  quo_p  [FRAC_BITS];
	logic [LEN_W:0]        cur    [FRAC_BITS];
	logic                  ge     [FRAC_BITS];

	// the low dividend bits are the zero fraction, so only a zero comes down
	always_comb begin
		for (int j = 0; j < FRAC_BITS; j++) begin
			if (j == 0) begin
				len_p[j] = in_len;
				rem_p[j] = {{(LEN_W-CW){1'b0}}, max_change};
				quo_p[j] = '0;
			end else begin
				len_p[j] = len_s[j-1];
				rem_p[j] = rem_s[j-1];
				quo_p[j] = quo_s[j-1];
			end
			cur[j] = {rem_p[j], 1'b0};
			ge[j]  = cur[j] >= {1'b0, len_p[j]};
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[FRAC_BITS-2:0], in_valid};
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < FRAC_BITS; j++) begin
				side_s[j] <= (j == 0) ? in_side : side_s[j-1];
				len_s[j]  <= len_p[j];
				rem_s[j]  <= ge[j] ? LEN_W'(cur[j] - {1'b0, len_p[j]}) : cur[j][LEN_W-1:0];
				quo_s[j]  <= {quo_p[j][FRAC_BITS-2:0], ge[j]};
			end
		end
	end

	assign out_valid = vld_s[FRAC_BITS-1];
	assign out_side  = side_s[FRAC_BITS-1];
	assign out_ratio = quo_s[FRAC_BITS-1];

	// on a clamped particle the remainder stays below the length
	for (genvar gj = 0; gj < FRAC_BITS; gj++) begin : g_chk
		assert property (@(posedge clk) disable iff (!arst_n)
			(vld_s[gj] && side_s[gj].clamp) |-> (rem_s[gj] < len_s[gj]))
			else $error("clamp divider remainder not below length");
	end

endmodule

>>> dv/pidb_checker.sv
// result checker for the particle drag and buoyancy core: watches channels, predicts, compares
module pidb_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [pidb_pkg::IN_W-1:0]      s_tdata,
	input  logic [0:0]                     s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [pidb_pkg::OUT_W-1:0]     m_tdata,
	input  logic [0:0]                     m_tuser,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [pidb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pidb_pkg::VW-1:0]        cfg_data,
	output int                             errors,
	output int                             pending,
	output int                             coupled_seen
);
	import pidb_pkg::*;

	localparam longint ONE = longint'(1) << FRAC_BITS;

	typedef struct {
		logic [VW-1:0] vel [AXES];
		logic          coupled;
	} particle_out_t;

	// shadow copy of the register file
	longint unsigned drag_c, dt_q, max_drag, max_accel;
	longint          ambient, gain;

	particle_out_t expected_vel [$];

	function automatic longint unsigned abs64(input longint x);
		return x < 0 ? longint'(-x) : x;
	endfunction

	function automatic longint clip32(input longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// implicit drag, change clamp and clamped buoyancy for one particle
	function automatic particle_out_t drag_buoy_update(input logic [IN_W-1:0] td, input logic surf);
		particle_out_t   o;
		longint          v [AXES];
		longint          g [AXES];
		longint          nv [AXES];
		longint          d [AXES];
		longint          temp, k, den, r, dtemp, a;
		longint unsigned kp, sum, len, m;
		int              s;
		temp = longint'($signed(td[6*VW +: VW]));
		for (int i = 0; i < AXES; i++) begin
			v[i]  = longint'($signed(td[i*VW +: VW]));
			g[i]  = longint'($signed(td[(3+i)*VW +: VW]));
			nv[i] = v[i];
		end
		if (surf) begin
			kp  = (drag_c * dt_q) >> FRAC_BITS;
			k   = kp > 64'h7FFF_FFFF ? 64'sh7FFF_FFFF : longint'(kp);
			den = ONE + k;
			s   = 0;
			sum = 0;
			for (int i = 0; i < AXES; i++) begin
				nv[i] = (v[i] * ONE + k * g[i]) / den;
				d[i]  = nv[i] - v[i];
				if (abs64(d[i]) >= 64'h8000_0000) s = 1;
			end
			for (int i = 0; i < AXES; i++) begin
				m = abs64(d[i]) >> s;
				sum += m * m;
			end
			len = floor_sqrt(sum) << s;
			// scale the change back onto the allowed length
			if (len > max_drag) begin
				r = longint'((max_drag * 64'd65536) / len);
				for (int i = 0; i < AXES; i++) nv[i] = v[i] + (d[i] * r) / ONE;
			end
			for (int i = 0; i < AXES; i++) nv[i] = clip32(nv[i]);
			// buoyancy only above ambient
			dtemp = temp - ambient;
			if (dtemp < 0) dtemp = 0;
			a = (gain * dtemp) / ONE;
			if (abs64(a) > max_accel) a = a < 0 ? -longint'(max_accel) : longint'(max_accel);
			nv[1] = clip32(nv[1] + (a * longint'(dt_q)) / ONE);
		end
		for (int i = 0; i < AXES; i++) o.vel[i] = nv[i][VW-1:0];
		o.coupled = surf;
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [VW-1:0] got,
			input logic [VW-1:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		errors++;
	endtask

	assign pending = expected_vel.size();

	// register writes mirror the block's register file
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drag_c    <= 65536;
			dt_q      <= 1092;
			max_drag  <= 65536;
			ambient   <= 0;
			gain      <= 65536;
			max_accel <= 131072;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DRAG_COEF: drag_c    <= cfg_data[CW-1:0];
				REG_TIME_STEP: dt_q      <= cfg_data[CW-1:0];
				REG_MAX_DRAG:  max_drag  <= cfg_data[CW-1:0];
				REG_AMBIENT:   ambient   <= longint'($signed(cfg_data));
				REG_BUOY_GAIN: gain      <= longint'($signed(cfg_data));
				REG_MAX_ACCEL: max_accel <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	initial begin
		errors = 0;
		coupled_seen = 0;
	end

	// predict on each input transfer, compare on each output transfer
	always @(posedge clk) begin
		particle_out_t want;
		if (arst_n && s_tvalid && s_tready)
			expected_vel = {expected_vel, drag_buoy_update(s_tdata, s_tuser[0])};
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_vel.size() == 0) begin
				$display("unexpected output transfer %h", m_tdata);
				errors++;
			end else begin
				want = expected_vel.pop_front();
				for (int i = 0; i < AXES; i++)
					if (m_tdata[i*VW +: VW] !== want.vel[i])
						report_mismatch($sformatf("new_vel[%0d]", i), m_tdata[i*VW +: VW],
							want.vel[i]);
				if (m_tuser[0] !== want.coupled)
					report_mismatch("was_coupled", m_tuser[0], want.coupled);
				if (want.coupled) coupled_seen++;
			end
		end
	end

endmodule

>>> dv/tb_top.sv
// testbench top for the particle drag and buoyancy core: stimulus, idling and verdict
module tb_top;
	import pidb_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 120;
	localparam int PHASES = 7;
	localparam int ITEMS_PER_PHASE = 262;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid, s_tready;
	logic [IN_W-1:0]      s_tdata;
	logic [0:0]           s_tuser;
	logic                 m_tvalid, m_tready;
	logic [OUT_W-1:0]     m_tdata;
	logic [0:0]           m_tuser;
	logic                 cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VW-1:0]        cfg_data;
	int                   errors, pending, coupled_seen;
	int                   burst_left, idle_cycles, sent;

	particle_implicit_drag_buoyancy_core DUT (.*);

	pidb_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver stall pattern, mode redrawn at random whenever the free-running stall counter hits a multiple of 64
	int stall_mode, stall_cnt;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_mode <= 0;
			stall_cnt  <= 0;
		end else begin
			stall_cnt <= stall_cnt + 1;
			if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= $urandom_range(0, 1);
				2: m_tready <= ($urandom_range(0, 9) != 0);
				default: m_tready <= ((stall_cnt / 8) % 3 != 0);
			endcase
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("particle_implicit_drag_buoyancy_core verification failed");
			$finish;
		end
	end

	function automatic logic [VW-1:0] rand_q();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1 << 20) - (1 << 19);
			2: case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h0;
				default: return 32'hFFFF_FFFF;
			endcase
			default: return $urandom_range(0, 1 << 25) - (1 << 24);
		endcase
	endfunction

	// one particle transfer, usually with a random gap when a burst runs out
	task automatic send_particle(input logic [VW-1:0] vx, vy, vz, gx, gy, gz, temp,
			input logic surf);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {temp, gz, gy, gx, vz, vy, vx};
		s_tuser  <= surf;
		@(posedge clk);
		while (!(s_tvalid && s_tready)) @(posedge clk);
		sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one register transfer; the caller drops cfg_valid after the last one
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!(cfg_valid && cfg_ready)) @(posedge clk);
	endtask

	task automatic load_settings(input int phase);
		logic [VW-1:0] vals [6];
		case (phase)
			1: vals = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
			2: vals = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
				32'h7FFF_FFFF, 32'h7FFF_FFFF};
			3: vals = '{32'h0002_0000, 32'h0000_4000, 32'h0, 32'h7FFF_FFFF,
				32'h8000_0000, 32'h0};
			default: vals = '{$urandom_range(0, 1 << 20), $urandom_range(0, 1 << 16),
				$urandom_range(0, 1 << 20), rand_q(), $urandom, $urandom_range(0, 1 << 20)};
		endcase
		wait_drained();
		write_reg(REG_DRAG_COEF, vals[0]);
		write_reg(REG_TIME_STEP, vals[1]);
		write_reg(REG_MAX_DRAG, vals[2]);
		write_reg(REG_AMBIENT, vals[3]);
		write_reg(REG_BUOY_GAIN, vals[4]);
		write_reg(REG_MAX_ACCEL, vals[5]);
		// unused index must be ignored
		write_reg(REG_UNUSED, $urandom);
		cfg_valid <= 1'b0;
		// let the drag factor settle
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [VW-1:0] vx, vy, vz;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = '0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_DRAG_COEF;
		cfg_data   = '0;
		burst_left = 0;
		idle_cycles = 0;
		sent       = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: passthrough, extremes, cold gas, hot gas, clamped drag
		send_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 32'h2, 32'h3, 32'h7FFF_FFFF, 1'b0);
		send_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 1'b0);
		send_particle(0, 0, 0, 0, 0, 0, 0, 1'b1);
		send_particle(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0002_0000,
			32'hFFFF_0000, 32'h8000_0000, 1'b1);
		send_particle(0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		send_particle(0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
		send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h0010_0000, 1'b1);
		send_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h0000_8000, 1'b1);
		send_particle(32'h0000_1000, 32'h0, 32'h0, 32'h0000_2000, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1);
		send_particle(32'h7FFF_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_0000, 32'h7FFF_FFFF, 0,
			32'h7FFF_FFFF, 1'b1);
		send_particle(32'h0, 32'h8000_0000, 0, 0, 32'h8000_0000, 0, 32'h0005_0000, 1'b1);
		load_settings(2);
		send_particle(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		send_particle(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0,
			32'h8000_0000, 1'b1);
		send_particle(32'h1234_5678, 32'h8765_4321, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
		load_settings(0);

		// random phases across register settings
		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) load_settings(p);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				vx = rand_q();
				vy = rand_q();
				vz = rand_q();
				// gas near particle velocity half the time
				if ($urandom_range(0, 1))
					send_particle(vx, vy, vz, rand_q(), rand_q(), rand_q(), rand_q(),
						$urandom_range(0, 7) != 0);
				else
					send_particle(vx, vy, vz, vx + $urandom_range(0, 1 << 18) - (1 << 17),
						vy + $urandom_range(0, 1 << 18) - (1 << 17), vz ^ $urandom_range(0, 255),
						rand_q(), $urandom_range(0, 7) != 0);
				if (p == 3 && n == ITEMS_PER_PHASE / 2) wait_drained();
			end
		end

		wait_drained();
		$display("sent %0d particles over %0d register settings, %0d coupled results checked",
			sent, PHASES + 2, coupled_seen);
		if (errors == 0)
			$display("particle_implicit_drag_buoyancy_core verification clean");
		else
			$display("particle_implicit_drag_buoyancy_core verification failed");
		$finish;
	end

endmodule
